FILE: src/wwti_pkg.sv
// ----------------------------------------------------------------------------
// wwti_pkg
// Shared types, constants and weight tables of the wall weight interpolator.
// ----------------------------------------------------------------------------
package wwti_pkg;

  localparam int unsigned DataW    = 24;
  localparam int unsigned NumPts   = 50;
  localparam int unsigned NumTabs  = 5;
  localparam int unsigned FracW    = 20;
  localparam int unsigned UBits    = 26;
  localparam int unsigned DivStep  = 2;
  localparam int unsigned DivStgs  = UBits / DivStep;
  localparam int unsigned ProdW    = 30;
  localparam int unsigned LowBits  = ProdW - DataW;
  localparam logic [DataW-1:0] WMax = '1;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_DIMENSION   = 2'd0,
    REG_WEIGHT_TYPE = 2'd1,
    REG_RADIUS      = 2'd2,
    REG_EXTRAPOLATE = 2'd3
  } wwti_reg_e;

  localparam logic [DataW-1:0] ResetRadius = 24'd65536;

  // divider result handed to the interpolator
  typedef struct packed {
    logic [UBits-1:0] u;
    logic             ovf;
  } wwti_div_t;

  // decimal scale factors, value in units of 1e-15 per mantissa step
  localparam longint unsigned X1 = 64'd10000000000;
  localparam longint unsigned X0 = 64'd1000000000;
  localparam longint unsigned N1 = 64'd100000000;
  localparam longint unsigned N2 = 64'd10000000;
  localparam longint unsigned N3 = 64'd1000000;
  localparam longint unsigned N4 = 64'd100000;
  localparam longint unsigned N5 = 64'd10000;
  localparam longint unsigned N6 = 64'd1000;
  localparam longint unsigned N9 = 64'd1;
  localparam longint unsigned QHalf = 64'd30517578125;
  localparam longint unsigned QDen  = 64'd61035156250;

  // round a decimal mantissa to Q4.20, ties upward
  function automatic logic [DataW-1:0] qv(input longint unsigned m,
                                          input longint unsigned sc);
    longint unsigned r;
    r = (m * sc * 64'd64 + QHalf) / QDen;
    return r[DataW-1:0];
  endfunction

  localparam logic [DataW-1:0] WTab [NumTabs][NumPts] = '{
    '{ // 2D
      qv(5241062,X0),qv(4806382,X0),qv(4410487,X0),qv(4054778,X0),qv(3730637,X0),
      qv(3429948,X0),qv(3149566,X0),qv(2886979,X0),qv(2666136,X0),qv(2467269,X0),
      qv(2280089,X0),qv(2103452,X0),qv(1936385,X0),qv(1778054,X0),qv(1641818,X0),
      qv(1517942,X0),qv(1400164,X0),qv(1288030,X0),qv(1181136,X0),qv(1079119,X0),
      qv(9816527,N1),qv(8884420,N1),qv(7992183,N1),qv(7137363,N1),qv(6317716,N1),
      qv(5531178,N1),qv(4775850,N1),qv(4049977,N1),qv(3351934,N1),qv(2680213,N1),
      qv(2033415,N1),qv(1410236,N1),qv(1134677,N1),qv(8921162,N2),qv(6598985,N2),
      qv(4373757,N2),qv(2239533,N2),qv(1908397,N3),24'd0,24'd0,
      24'd0,24'd0,24'd0,24'd0,24'd0,24'd0,24'd0,24'd0,24'd0,24'd0},
    '{ // 3D type 0
      qv(8806738,X0),qv(8181128,X0),qv(7606205,X0),qv(7077553,X0),qv(6583733,X0),
      qv(6113077,X0),qv(5662959,X0),qv(5231327,X0),qv(4868527,X0),qv(4537055,X0),
      qv(4218042,X0),qv(3910643,X0),qv(3614143,X0),qv(3327929,X0),qv(3065546,X0),
      qv(2817415,X0),qv(2577400,X0),qv(2345152,X0),qv(2120345,X0),qv(1902679,X0),
      qv(1691872,X0),qv(1487658,X0),qv(1289784,X0),qv(1098012,X0),qv(9121101,N1),
      qv(7871401,N1),qv(6699803,N1),qv(5570121,N1),qv(4480352,N1),qv(3428608,N1),
      qv(2413113,N1),qv(1432186,N1),qv(1134677,N1),qv(8921162,N2),qv(6598985,N2),
      qv(4373757,N2),qv(2239533,N2),qv(1908397,N3),24'd0,24'd0,
      24'd0,24'd0,24'd0,24'd0,24'd0,24'd0,24'd0,24'd0,24'd0,24'd0},
    '{ // 3D type 1
      qv(4283453,X0),qv(3870382,X0),qv(3499389,X0),qv(3164078,X0),qv(2859517,X0),
      qv(2582070,X0),qv(2328922,X0),qv(2097837,X0),qv(1886323,X0),qv(1691247,X0),
      qv(1511369,X0),qv(1345706,X0),qv(1193412,X0),qv(1053747,X0),qv(9258529,N1),
      qv(8086067,N1),qv(7014818,N1),qv(6040244,N1),qv(5158145,N1),qv(4364597,N1),
      qv(3655917,N1),qv(3028630,N1),qv(2479442,N1),qv(2005228,N1),qv(1603010,N1),
      qv(1262202,N1),qv(9705254,N2),qv(7255457,N2),qv(5250003,N2),qv(3667598,N2),
      qv(2488189,N2),qv(1692868,N2),qv(1156289,N2),qv(7306856,N3),qv(4085086,N3),
      qv(1832813,N3),qv(4905643,N4),qv(3635042,N6),24'd0,24'd0,
      24'd0,24'd0,24'd0,24'd0,24'd0,24'd0,24'd0,24'd0,24'd0,24'd0},
    '{ // 3D type 2
      qv(1333002,X1),qv(1249187,X1),qv(1171302,X1),qv(1099103,X1),qv(1030795,X1),
      qv(9644084,X0),qv(8996997,X0),qv(8364818,X0),qv(7850731,X0),qv(7382863,X0),
      qv(6924716,X0),qv(6475580,X0),qv(6034875,X0),qv(5602110,X0),qv(5205239,X0),
      qv(4826222,X0),qv(4453319,X0),qv(4086279,X0),qv(3724876,X0),qv(3368899,X0),
      qv(3018153,X0),qv(2672453,X0),qv(2331625,X0),qv(1995500,X0),qv(1663919,X0),
      qv(1448060,X0),qv(1242908,X0),qv(1041470,X0),qv(8435703,N1),qv(6490457,N1),
      qv(4577407,N1),qv(2695085,N1),qv(2153724,N1),qv(1711164,N1),qv(1278946,N1),
      qv(8564234,N2),qv(4430009,N2),qv(3813159,N3),24'd0,24'd0,
      24'd0,24'd0,24'd0,24'd0,24'd0,24'd0,24'd0,24'd0,24'd0,24'd0},
    '{ // 3D type 3
      qv(9067981,N1),qv(8370517,N1),qv(7701090,N1),qv(7060559,N1),qv(6449566,N1),
      qv(5868508,N1),qv(5317509,N1),qv(4796413,N1),qv(4304862,N1),qv(3843025,N1),
      qv(3411226,N1),qv(3009548,N1),qv(2637830,N1),qv(2295669,N1),qv(1982462,N1),
      qv(1697668,N1),qv(1440694,N1),qv(1210741,N1),qv(1006813,N1),qv(8277293,N2),
      qv(6721277,N2),qv(5384792,N2),qv(4250950,N2),qv(3301353,N2),qv(2516181,N2),
      qv(1875377,N2),qv(1363023,N2),qv(9640624,N3),qv(6628462,N3),qv(4431749,N3),
      qv(2883400,N3),qv(1811604,N3),qv(1058238,N3),qv(5494491,N4),qv(2372314,N4),
      qv(7358514,N5),qv(1051031,N5),qv(6910701,N9),24'd0,24'd0,
      24'd0,24'd0,24'd0,24'd0,24'd0,24'd0,24'd0,24'd0,24'd0,24'd0}
  };

endpackage

FILE: src/wwti_if.sv
// ----------------------------------------------------------------------------
// wwti_if
// Valid/ready channels of the wall weight interpolator.
// ----------------------------------------------------------------------------
interface wwti_dist_if;
  logic        valid;
  logic        ready;
  logic [23:0] distance;
  modport source (output valid, output distance, input ready);
  modport sink   (input valid, input distance, output ready);
endinterface

interface wwti_weight_if;
  logic        valid;
  logic        ready;
  logic [23:0] weight;
  modport source (output valid, output weight, input ready);
  modport sink   (input valid, input weight, output ready);
endinterface

interface wwti_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [23:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: src/wall_weight_table_interpolator.sv
// ----------------------------------------------------------------------------
// wall_weight_table_interpolator
// Wall weight from a wall distance by table interpolation over r/re.
// ----------------------------------------------------------------------------
// One distance enters per cycle unless back-pressure fills the pipe; its
// weight passes a scaling stage, thirteen divider stages at two quotient
// bits each for the ratio distance/radius, then table read, multiply and
// round stages. The thirteen-stage divider is the longest part; back-pressure
// on the result stalls only the stages that hold items. Configuration writes
// are taken every cycle and must only happen while no item is in flight.
module wall_weight_table_interpolator (
  input  logic                clk_i,
  input  logic                rst_ni,
  wwti_cfg_if.sink            cfg_i,
  wwti_dist_if.sink           dist_i,
  wwti_weight_if.source       weight_o
);
  import wwti_pkg::*;

  logic [1:0]       dimension_q, weight_type_q;
  logic [DataW-1:0] radius_q;
  logic             extrapolate_q;

  // hold the configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dimension_q   <= 2'd3;
      weight_type_q <= 2'd0;
      radius_q      <= ResetRadius;
      extrapolate_q <= 1'b1;
    end else if (cfg_i.valid) begin
      case (wwti_reg_e'(cfg_i.index))
        REG_DIMENSION:   dimension_q   <= cfg_i.data[1:0];
        REG_WEIGHT_TYPE: weight_type_q <= cfg_i.data[1:0];
        REG_RADIUS:      radius_q      <= cfg_i.data;
        REG_EXTRAPOLATE: extrapolate_q <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  logic      div_valid, div_ready;
  wwti_div_t div_out;

  wwti_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .radius_i    (radius_q),
    .in_valid_i  (dist_i.valid),
    .in_ready_o  (dist_i.ready),
    .distance_i  (dist_i.distance),
    .out_valid_o (div_valid),
    .out_ready_i (div_ready),
    .out_o       (div_out)
  );

  wwti_interp u_interp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .dimension_i   (dimension_q),
    .weight_type_i (weight_type_q),
    .extrapolate_i (extrapolate_q),
    .in_valid_i    (div_valid),
    .in_ready_o    (div_ready),
    .in_i          (div_out),
    .out_valid_o   (weight_o.valid),
    .out_ready_i   (weight_o.ready),
    .weight_o      (weight_o.weight)
  );

  // input stalls only when the pipe is full behind a waiting result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !dist_i.ready |-> (weight_o.valid && !weight_o.ready))
    else $error("input stalled without output back-pressure");

  // the divider stalls only when the interpolator is backed up
  a_div_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_valid && !div_ready) |-> (weight_o.valid && !weight_o.ready))
    else $error("divider stalled without output back-pressure");

  // a zero radius always yields a zero weight
  a_zero_radius: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (weight_o.valid && radius_q == '0) |-> (weight_o.weight == '0))
    else $error("nonzero weight with zero radius");

endmodule

FILE: src/wwti_div.sv
// ----------------------------------------------------------------------------
// wwti_div
// Pipelined restoring divider: u = floor(distance * 50 * 2^20 / radius),
// two quotient bits per stage, with an overflow flag for u >= 2^26.
// ----------------------------------------------------------------------------
module wwti_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [wwti_pkg::DataW-1:0]  radius_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [wwti_pkg::DataW-1:0]  distance_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output wwti_pkg::wwti_div_t         out_o
);
  import wwti_pkg::*;

  localparam int unsigned NStg = DivStgs + 1;

  logic                 v_q   [NStg];
  logic [DataW-1:0]     rem_q [NStg];
  logic [UBits-1:0]     nb_q  [NStg];
  logic [UBits-1:0]     quo_q [NStg];
  logic                 ovf_q [NStg];
  logic                 rdy   [NStg+1];

  logic [ProdW-1:0]     prod;

  assign rdy[NStg] = out_ready_i;

  // front stage: scale the distance and check the quotient range
  assign prod = ProdW'(distance_i) * ProdW'(50);
  assign rdy[0] = !v_q[0] || rdy[1];
  assign in_ready_o = rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (rdy[0]) begin
      v_q[0] <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && in_valid_i) begin
      rem_q[0] <= prod[ProdW-1:LowBits];
      nb_q[0]  <= {prod[LowBits-1:0], {FracW{1'b0}}};
      quo_q[0] <= '0;
      ovf_q[0] <= prod >= {radius_i, {LowBits{1'b0}}};
    end
  end

  // quotient stages
  for (genvar s = 1; s < NStg; s++) begin : g_stg
    logic [DataW-1:0] rem_n [DivStep+1];
    logic [UBits-1:0] nb_n  [DivStep+1];
    logic [UBits-1:0] quo_n [DivStep+1];

    always_comb begin
      logic [DataW:0] t;
      rem_n[0] = rem_q[s-1];
      nb_n[0]  = nb_q[s-1];
      quo_n[0] = quo_q[s-1];
      for (int b = 0; b < DivStep; b++) begin
        t = {rem_n[b], nb_n[b][UBits-1]};
        nb_n[b+1]  = {nb_n[b][UBits-2:0], 1'b0};
        if (t >= {1'b0, radius_i}) begin
          rem_n[b+1] = DataW'(t - {1'b0, radius_i});
          quo_n[b+1] = {quo_n[b][UBits-2:0], 1'b1};
        end else begin
          rem_n[b+1] = t[DataW-1:0];
          quo_n[b+1] = {quo_n[b][UBits-2:0], 1'b0};
        end
      end
    end

    assign rdy[s] = !v_q[s] || rdy[s+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (rdy[s]) begin
        v_q[s] <= v_q[s-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[s] && v_q[s-1]) begin
        rem_q[s] <= rem_n[DivStep];
        nb_q[s]  <= nb_n[DivStep];
        quo_q[s] <= quo_n[DivStep];
        ovf_q[s] <= ovf_q[s-1];
      end
    end
  end

  assign out_valid_o = v_q[NStg-1];
  assign out_o.u     = quo_q[NStg-1];
  assign out_o.ovf   = ovf_q[NStg-1];

endmodule

FILE: src/wwti_interp.sv
// ----------------------------------------------------------------------------
// wwti_interp
// Segment choice and table read, slope multiply, then round and saturate.
// ----------------------------------------------------------------------------
module wwti_interp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [1:0]                  dimension_i,
  input  logic [1:0]                  weight_type_i,
  input  logic                        extrapolate_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  wwti_pkg::wwti_div_t         in_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [wwti_pkg::DataW-1:0]  weight_o
);
  import wwti_pkg::*;

  localparam int unsigned SegW = $clog2(NumPts);
  localparam int unsigned FW   = FracW + 2;
  localparam int unsigned DW   = DataW + 1;
  localparam int unsigned PW   = DW + FW;
  localparam int unsigned AccW = DataW + FracW + 4;
  localparam logic [UBits-1:0] ULast = UBits'(NumPts - 1) << FracW;
  localparam logic [UBits-1:0] UEnd  = UBits'(NumPts) << FracW;
  localparam logic [UBits-1:0] UOne  = UBits'(1) << FracW;

  logic rdy_a, rdy_b, rdy_c;
  logic v_a_q, v_b_q, v_c_q;

  // stage A: pick the segment and read both end points
  logic [SegW-1:0]  seg, segp1;
  logic [UBits-1:0] um1, xr;
  logic [2:0]       sel;
  logic [DataW-1:0] yl, yr;
  logic [UBits:0]   fw;

  logic                   zero_a_q, zero_b_q, zero_c_q;
  logic [DataW-1:0]       yl_a_q, yl_b_q;
  logic signed [DW-1:0]   diff_a_q;
  logic signed [FW-1:0]   f_a_q;
  logic signed [PW-1:0]   prod_b_q;
  logic [DataW-1:0]       w_c_q;

  always_comb begin
    um1 = in_i.u - UBits'(1);
    if (in_i.u >= ULast) begin
      seg = SegW'(NumPts - 2);
    end else if (in_i.u <= UOne) begin
      seg = '0;
    end else begin
      seg = um1[FracW +: SegW] - SegW'(1);
    end
    segp1 = seg + SegW'(1);
    xr    = {segp1, {FracW{1'b0}}};
    sel   = (dimension_i == 2'd2) ? 3'd0 : ({1'b0, weight_type_i} + 3'd1);
    yl    = WTab[sel][seg];
    yr    = WTab[sel][segp1];
    if (!extrapolate_i && (in_i.u < xr)) begin
      yr = yl;
    end
    fw = {1'b0, in_i.u} - {1'b0, xr};
  end

  assign rdy_a      = !v_a_q || rdy_b;
  assign rdy_b      = !v_b_q || rdy_c;
  assign rdy_c      = !v_c_q || out_ready_i;
  assign in_ready_o = rdy_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_a_q <= 1'b0;
      v_b_q <= 1'b0;
      v_c_q <= 1'b0;
    end else begin
      if (rdy_a) v_a_q <= in_valid_i;
      if (rdy_b) v_b_q <= v_a_q;
      if (rdy_c) v_c_q <= v_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_a && in_valid_i) begin
      zero_a_q <= in_i.ovf || (in_i.u >= UEnd);
      yl_a_q   <= yl;
      diff_a_q <= $signed({1'b0, yr}) - $signed({1'b0, yl});
      f_a_q    <= $signed(fw[FW-1:0]);
    end
  end

  // stage B: slope times offset
  always_ff @(posedge clk_i) begin
    if (rdy_b && v_a_q) begin
      zero_b_q <= zero_a_q;
      yl_b_q   <= yl_a_q;
      prod_b_q <= PW'(diff_a_q) * PW'(f_a_q);
    end
  end

  // stage C: add the base, round half up and clamp
  logic signed [AccW-1:0] acc, accr;
  logic [AccW-FracW-1:0]  wr;
  logic [DataW-1:0]       wsat;

  always_comb begin
    acc  = $signed({4'b0, yl_b_q, {FracW{1'b0}}}) + AccW'(prod_b_q);
    accr = acc + AccW'(1 << (FracW - 1));
    wr   = accr[AccW-1:FracW];
    if (zero_b_q || acc <= 0) begin
      wsat = '0;
    end else if (wr > (AccW-FracW)'(WMax)) begin
      wsat = WMax;
    end else begin
      wsat = wr[DataW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_c && v_b_q) begin
      zero_c_q <= zero_b_q;
      w_c_q    <= wsat;
    end
  end

  assign out_valid_o = v_c_q;
  assign weight_o    = zero_c_q ? '0 : w_c_q;

endmodule
